// ===== sv/rrj_pkg.sv =====
// Shared types, widths and constants for the rigid rotation Jacobian unit.
// No dependencies; imported by every module of the block.
package rrj_pkg;

    localparam int TRIG_W         = 16;
    localparam int OP_W           = TRIG_W + 1;
    localparam int AB_W           = 2 * OP_W;
    localparam int COEF42_W       = 47;
    localparam int COEF_FRAC_DROP = 14;
    localparam int COEF_W         = COEF42_W - COEF_FRAC_DROP;
    localparam int PT_W           = 24;
    localparam int PROD_W         = COEF_W + PT_W;
    localparam int SUM_W          = PROD_W + 2;
    localparam int SUM_DROP       = 16;
    localparam int T_W            = SUM_W - SUM_DROP;
    localparam int RAD_W          = 12;
    localparam int SCL_W          = T_W + RAD_W;
    localparam int SCL_DROP       = 28;
    localparam int RND_W          = SCL_W - SCL_DROP;
    localparam int STAGES         = 8;
    localparam int PT_STAGES      = 4;
    localparam int SEL_STAGES     = STAGES - 1;
    localparam int CFG_IDX_W      = 3;
    localparam int SEL_W          = 3;
    localparam int AXIS_DATA_W    = 3 * PT_W;

    typedef logic signed [TRIG_W-1:0]   t_trig;
    typedef logic signed [OP_W-1:0]     t_op;
    typedef logic signed [AB_W-1:0]     t_ab;
    typedef logic signed [COEF42_W-1:0] t_coef42;
    typedef logic signed [COEF_W-1:0]   t_coef;
    typedef logic signed [PT_W-1:0]     t_pt;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic signed [SUM_W-1:0]    t_sum;
    typedef logic signed [T_W-1:0]      t_t;
    typedef logic signed [SCL_W-1:0]    t_scl;
    typedef logic signed [RND_W-1:0]    t_rnd;

    localparam t_trig   TRIG_ONE        = 16'sd16384;
    localparam t_op     ONE_Q14         = 17'sd16384;
    localparam t_op     OP_ZERO         = '0;
    localparam t_pt     ONE_Q8          = 24'sd256;
    localparam t_pt     OUT_MAX         = 24'sh7FFFFF;
    localparam t_pt     OUT_MIN         = 24'sh800000;
    localparam logic signed [RAD_W-1:0] RAD_PER_DEG_Q16 = 12'sd1144;
    localparam t_coef42 COEF_HALF       = t_coef42'(1) <<< (COEF_FRAC_DROP - 1);
    localparam t_sum    SUM_HALF        = t_sum'(1) <<< (SUM_DROP - 1);
    localparam t_scl    SCL_HALF        = t_scl'(1) <<< (SCL_DROP - 1);

    typedef enum logic [SEL_W-1:0] {
        SEL_TX = 3'd0,
        SEL_TY = 3'd1,
        SEL_TZ = 3'd2,
        SEL_RX = 3'd3,
        SEL_RY = 3'd4,
        SEL_RZ = 3'd5
    } t_param_sel;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIN_X = 3'd0,
        CFG_COS_X = 3'd1,
        CFG_SIN_Y = 3'd2,
        CFG_COS_Y = 3'd3,
        CFG_SIN_Z = 3'd4,
        CFG_COS_Z = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        t_trig sx;
        t_trig cx;
        t_trig sy;
        t_trig cy;
        t_trig sz;
        t_trig cz;
    } t_trig_regs;

    // coefficient = a*b*c + d*e*2^14, all in Q.42
    typedef struct packed {
        t_op a;
        t_op b;
        t_op c;
        t_op d;
        t_op e;
    } t_coef_ops;

    function automatic t_coef_ops mk_ops(input t_op a, input t_op b, input t_op c,
                                         input t_op d, input t_op e);
        t_coef_ops res;
        res.a = a;
        res.b = b;
        res.c = c;
        res.d = d;
        res.e = e;
        return res;
    endfunction

endpackage

// ===== sv/rrj_coef_sel.sv =====
// Stage 1: picks the trig operands of all nine coefficients for the selector.
// Depends on rrj_pkg.
module rrj_coef_sel (
    input  logic                i_clk,
    input  logic                i_en,
    input  rrj_pkg::t_trig_regs i_trig,
    input  rrj_pkg::t_param_sel i_sel,
    output rrj_pkg::t_coef_ops  o_ops [3][3]
);
    import rrj_pkg::*;

    t_op       sx, cx, sy, cy, sz, cz;
    t_op       nsx, ncx, nsy, ncy, nsz;
    t_coef_ops n_ops [3][3];
    t_coef_ops r_ops [3][3];

    assign sx  = t_op'(i_trig.sx);
    assign cx  = t_op'(i_trig.cx);
    assign sy  = t_op'(i_trig.sy);
    assign cy  = t_op'(i_trig.cy);
    assign sz  = t_op'(i_trig.sz);
    assign cz  = t_op'(i_trig.cz);
    assign nsx = -sx;
    assign ncx = -cx;
    assign nsy = -sy;
    assign ncy = -cy;
    assign nsz = -sz;

    // rows: output component; columns: point coordinate
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                n_ops[k][j] = '0;
            end
        end
        case (i_sel)
            SEL_RX: begin
                n_ops[1][0] = mk_ops(cx, sy, cz, sx, sz);
                n_ops[1][1] = mk_ops(cx, sy, sz, nsx, cz);
                n_ops[1][2] = mk_ops(OP_ZERO, OP_ZERO, OP_ZERO, cx, cy);
                n_ops[2][0] = mk_ops(nsx, sy, cz, cx, sz);
                n_ops[2][1] = mk_ops(nsx, sy, sz, ncx, cz);
                n_ops[2][2] = mk_ops(OP_ZERO, OP_ZERO, OP_ZERO, nsx, cy);
            end
            SEL_RY: begin
                n_ops[0][0] = mk_ops(OP_ZERO, OP_ZERO, OP_ZERO, nsy, cz);
                n_ops[0][1] = mk_ops(OP_ZERO, OP_ZERO, OP_ZERO, nsy, sz);
                n_ops[0][2] = mk_ops(OP_ZERO, OP_ZERO, OP_ZERO, ncy, ONE_Q14);
                n_ops[1][0] = mk_ops(sx, cy, cz, OP_ZERO, OP_ZERO);
                n_ops[1][1] = mk_ops(sx, cy, sz, OP_ZERO, OP_ZERO);
                n_ops[1][2] = mk_ops(OP_ZERO, OP_ZERO, OP_ZERO, nsy, sx);
                n_ops[2][0] = mk_ops(cx, cy, cz, OP_ZERO, OP_ZERO);
                n_ops[2][1] = mk_ops(cx, cy, sz, OP_ZERO, OP_ZERO);
                n_ops[2][2] = mk_ops(OP_ZERO, OP_ZERO, OP_ZERO, ncx, sy);
            end
            SEL_RZ: begin
                n_ops[0][0] = mk_ops(OP_ZERO, OP_ZERO, OP_ZERO, nsz, cy);
                n_ops[0][1] = mk_ops(OP_ZERO, OP_ZERO, OP_ZERO, cy, cz);
                n_ops[1][0] = mk_ops(nsx, sy, sz, ncx, cz);
                n_ops[1][1] = mk_ops(sx, sy, cz, ncx, sz);
                n_ops[2][0] = mk_ops(ncx, sy, sz, sx, cz);
                n_ops[2][1] = mk_ops(cx, sy, cz, sx, sz);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ops <= n_ops;
        end
    end

    assign o_ops = r_ops;

endmodule

// ===== sv/rrj_coef_mul.sv =====
// Stages 2..4: forms one coefficient a*b*c + d*e*2^14 in Q.42, rounds to Q.28.
// Depends on rrj_pkg.
module rrj_coef_mul (
    input  logic               i_clk,
    input  logic               i_en,
    input  rrj_pkg::t_coef_ops i_ops,
    output rrj_pkg::t_coef     o_coef
);
    import rrj_pkg::*;

    t_ab                      r_ab;
    t_op                      r_c;
    t_ab                      r_de;
    logic signed [AB_W+OP_W-1:0] n_abc;
    t_coef42                  r_abc;
    t_ab                      r_de2;
    t_coef42                  n_de_ext;
    t_coef42                  n_sum;
    t_coef                    r_coef;

    assign n_abc    = r_ab * r_c;
    assign n_de_ext = {{(COEF42_W - AB_W){r_de2[AB_W-1]}}, r_de2};
    assign n_sum    = r_abc + (n_de_ext <<< COEF_FRAC_DROP) + COEF_HALF;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ab   <= i_ops.a * i_ops.b;
            r_c    <= i_ops.c;
            r_de   <= i_ops.d * i_ops.e;
            r_abc  <= n_abc[COEF42_W-1:0];
            r_de2  <= r_de;
            r_coef <= n_sum[COEF42_W-1:COEF_FRAC_DROP];
        end
    end

    assign o_coef = r_coef;

endmodule

// ===== sv/rrj_dot.sv =====
// Stages 5..7: dot product of a coefficient row with the point, Q.20 rounding
// and degrees-to-radians scaling. Depends on rrj_pkg.
module rrj_dot (
    input  logic           i_clk,
    input  logic           i_en,
    input  rrj_pkg::t_coef i_coef [3],
    input  rrj_pkg::t_pt   i_pt [3],
    output rrj_pkg::t_scl  o_scl
);
    import rrj_pkg::*;

    t_prod r_prod [3];
    t_sum  n_sum;
    t_t    r_t;
    t_scl  r_scl;

    assign n_sum = $signed({{(SUM_W - PROD_W){r_prod[0][PROD_W-1]}}, r_prod[0]})
                 + $signed({{(SUM_W - PROD_W){r_prod[1][PROD_W-1]}}, r_prod[1]})
                 + $signed({{(SUM_W - PROD_W){r_prod[2][PROD_W-1]}}, r_prod[2]})
                 + SUM_HALF;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                r_prod[j] <= i_coef[j] * i_pt[j];
            end
            r_t   <= n_sum[SUM_W-1:SUM_DROP];
            r_scl <= r_t * RAD_PER_DEG_Q16;
        end
    end

    assign o_scl = r_scl;

endmodule

// ===== sv/rigid_rotation_jacobian_unit.sv =====
// Top level of the rigid rotation Jacobian unit: config registers, stream
// handshake, delay lines and output stage. Depends on rrj_pkg, rrj_coef_sel,
// rrj_coef_mul and rrj_dot.
//
// Input stream (s_axis): one transaction per point, tuser carries the parameter
// selector, tdata the point. Output stream (m_axis): one transaction per input,
// in order, with the three derivative components and the bad-selector flag.
// Configuration: i_cfg_we writes i_cfg_wdata into trig register i_cfg_idx
// (0..5: sin x, cos x, sin y, cos y, sin z, cos z, Q2.14); other indexes are
// ignored. Write only while no transaction is in flight.
// A transaction passes all eight pipeline stages from input to output; throughput
// is one transaction per cycle while the receiver keeps m_axis_tready high.
// When the receiver holds m_axis_tready low with a result waiting, the whole
// pipeline freezes and s_axis_tready drops; nothing is lost or repeated.
// Reset empties the pipeline and loads the identity rotation (sines 0,
// cosines 1.0).
module rigid_rotation_jacobian_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // point_x, point_y, point_z
    input  logic [rrj_pkg::AXIS_DATA_W-1:0]     s_axis_tdata,
    // param_sel
    input  logic [rrj_pkg::SEL_W-1:0]           s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // deriv_x, deriv_y, deriv_z
    output logic [rrj_pkg::AXIS_DATA_W-1:0]     m_axis_tdata,
    // bad_param
    output logic                                m_axis_tuser,
    input  logic                                i_cfg_we,
    input  logic [rrj_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [rrj_pkg::TRIG_W-1:0]          i_cfg_wdata
);
    import rrj_pkg::*;

    t_trig_regs       r_trig;
    logic [STAGES-1:0] r_vld;
    logic             en;
    t_param_sel       sel_in;
    t_pt              pt_in [3];
    t_param_sel       r_sel [SEL_STAGES];
    t_pt              r_pt [PT_STAGES][3];
    t_coef_ops        w_ops [3][3];
    t_coef            w_coef [3][3];
    t_scl             w_scl [3];
    t_pt              n_d [3];
    logic             n_bad;
    t_pt              r_d [3];
    logic             r_bad;

    function automatic t_pt rnd_sat(input t_scl v);
        t_scl b;
        t_rnd q;
        t_pt  res;
        b = v + SCL_HALF;
        q = b[SCL_W-1:SCL_DROP];
        if (q > t_rnd'(OUT_MAX)) begin
            res = OUT_MAX;
        end else if (q < t_rnd'(OUT_MIN)) begin
            res = OUT_MIN;
        end else begin
            res = q[PT_W-1:0];
        end
        return res;
    endfunction

    assign en            = !r_vld[STAGES-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign sel_in        = t_param_sel'(s_axis_tuser);

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            pt_in[j] = s_axis_tdata[j*PT_W +: PT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig.sx <= '0;
            r_trig.cx <= TRIG_ONE;
            r_trig.sy <= '0;
            r_trig.cy <= TRIG_ONE;
            r_trig.sz <= '0;
            r_trig.cz <= TRIG_ONE;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SIN_X: r_trig.sx <= i_cfg_wdata;
                CFG_COS_X: r_trig.cx <= i_cfg_wdata;
                CFG_SIN_Y: r_trig.sy <= i_cfg_wdata;
                CFG_COS_Y: r_trig.cy <= i_cfg_wdata;
                CFG_SIN_Z: r_trig.sz <= i_cfg_wdata;
                CFG_COS_Z: r_trig.cz <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[STAGES-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sel[0] <= sel_in;
            for (int i = 1; i < SEL_STAGES; i++) begin
                r_sel[i] <= r_sel[i-1];
            end
            r_pt[0] <= pt_in;
            for (int i = 1; i < PT_STAGES; i++) begin
                r_pt[i] <= r_pt[i-1];
            end
            r_d   <= n_d;
            r_bad <= n_bad;
        end
    end

    rrj_coef_sel u_coef_sel (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_trig (r_trig),
        .i_sel  (sel_in),
        .o_ops  (w_ops)
    );

    for (genvar k = 0; k < 3; k++) begin : g_comp
        for (genvar j = 0; j < 3; j++) begin : g_coord
            rrj_coef_mul u_coef_mul (
                .i_clk  (i_clk),
                .i_en   (en),
                .i_ops  (w_ops[k][j]),
                .o_coef (w_coef[k][j])
            );
        end
        rrj_dot u_dot (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_coef (w_coef[k]),
            .i_pt   (r_pt[PT_STAGES-1]),
            .o_scl  (w_scl[k])
        );
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_d[k] = '0;
        end
        n_bad = 1'b0;
        case (r_sel[SEL_STAGES-1])
            SEL_TX: n_d[0] = ONE_Q8;
            SEL_TY: n_d[1] = ONE_Q8;
            SEL_TZ: n_d[2] = ONE_Q8;
            SEL_RX, SEL_RY, SEL_RZ: begin
                for (int k = 0; k < 3; k++) begin
                    n_d[k] = rnd_sat(w_scl[k]);
                end
            end
            default: n_bad = 1'b1;
        endcase
    end

    assign m_axis_tvalid = r_vld[STAGES-1];
    assign m_axis_tdata  = {r_d[2], r_d[1], r_d[0]};
    assign m_axis_tuser  = r_bad;

`ifndef SYNTHESIS
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("bad selector result carries non-zero data");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && r_vld == '0)
        else $error("pipeline not empty after reset");

    a_vld_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |=> r_vld[0] == $past(s_axis_tvalid))
        else $error("input transaction not tracked into first stage");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |=> r_vld == $past(r_vld))
        else $error("valid bits moved during a stall");
`endif

endmodule
